// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent is checked in the same cycle as the antecedent.
`define CLPF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cell list pair filter: assertion failed");

// The consequent is checked in the cycle after the antecedent.
`define CLPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cell list pair filter: assertion failed");

`endif

// File: rtl/clpf_pkg.sv
package clpf_pkg;

	localparam int POS_W     = 32;
	localparam int INV_W     = 32;
	localparam int CPS_W     = 12;
	localparam int CNT_W     = 16;
	localparam int CONTACT_W = 16;
	localparam int BEAD_W    = 12;
	localparam int KIND_W    = 8;
	localparam int CMD_W     = 2;
	localparam int CELL_W    = 32;
	localparam int DIFF_W    = CELL_W + 1;
	localparam int CFG_IDX_W = 1;
	localparam int AXES      = 3;
	localparam int AXIS_W    = 2;

	// Remainder unit: four quotient digits are retired in each cycle.
	localparam int MOD_DIGITS = 4;
	localparam int MOD_STEPS  = (DIFF_W + MOD_DIGITS - 1) / MOD_DIGITS;
	localparam int MOD_W      = MOD_STEPS * MOD_DIGITS;
	localparam int STEP_W     = $clog2(MOD_STEPS);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MOD_STEPS - 1);

	localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(AXES - 1);

	// A list holds at most this many entries.
	localparam logic [CNT_W-1:0] COUNT_LIMIT = 16'hFFFF;

	localparam logic [INV_W-1:0] INV_RESET = 32'h0001_0000;
	localparam logic [CPS_W-1:0] CPS_RESET = 12'd16;

	localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL_SIZE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_CELLS_PER_SIDE = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_START   = 2'd0,
		CMD_ATTRACT = 2'd1,
		CMD_REPULSE = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_FIRST,
		ST_MUL_SECOND,
		ST_DIFF,
		ST_MOD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             done;
		logic [CPS_W-1:0] rem;
	} mod_res_t;

endpackage

// File: rtl/clpf_cell_index.sv
// Cell index of one coordinate: floor of the Q32.32 product, registered.
module clpf_cell_index import clpf_pkg::*; (
	input  logic                     clk,
	input  logic signed [POS_W-1:0]  pos,
	input  logic        [INV_W-1:0]  inv,
	output logic signed [CELL_W-1:0] cell_s1
);

	logic signed [POS_W+INV_W:0] product;

	// The arithmetic shift by the fraction width rounds towards minus infinity.
	assign product = pos * $signed({1'b0, inv});

	always_ff @(posedge clk) begin
		cell_s1 <= product[POS_W+INV_W-1:INV_W];
	end

endmodule

// File: rtl/clpf_mod_unit.sv
// Iterative restoring remainder: dividend modulo divisor, four bits per cycle.
module clpf_mod_unit import clpf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIFF_W-1:0] dividend,
	input  logic [CPS_W-1:0]  divisor,
	output mod_res_t          res
);

	logic [MOD_W-1:0]  shift_q;
	logic [CPS_W-1:0]  rem_q;
	logic [CPS_W-1:0]  divisor_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [MOD_W-1:0]  shift_nxt;
	logic [CPS_W-1:0]  rem_nxt;
	logic [CPS_W:0]    trial;

	always_comb begin
		rem_nxt   = rem_q;
		shift_nxt = shift_q;
		trial     = '0;
		for (int i = 0; i < MOD_DIGITS; i++) begin
			trial = {rem_nxt, shift_nxt[MOD_W-1]};
			if (trial >= {1'b0, divisor_q}) begin
				trial = trial - {1'b0, divisor_q};
			end
			rem_nxt   = trial[CPS_W-1:0];
			shift_nxt = {shift_nxt[MOD_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q   <= {{(MOD_W - DIFF_W){1'b0}}, dividend};
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			shift_q <= shift_nxt;
			rem_q   <= rem_nxt;
		end
	end

	assign res.done = done_q;
	assign res.rem  = rem_q;

endmodule

// File: rtl/cell_list_pair_filter_unit.sv
// Periodic cell-list pair filter. Each request carries one candidate bead pair for the
// attractive or the repulsive list. For each axis the block multiplies both positions by
// the inverse cell size in one shared 32 x 33 bit multiplier, takes the floor of the
// products as cell indices, and reduces the magnitude of their difference modulo
// cells_per_side in one shared remainder unit that retires four bits per cycle. The pair
// is kept when on every axis the remainder is 0, 1 or cells_per_side - 1 (with
// cells_per_side zero, the unit is skipped and the raw difference must lie in -1..+1);
// a kept pair leaves with the next 1-based slot of its list, or slot 0 once that list
// is full. An axis passes through two multiply states, a difference state and then the
// remainder unit; a rejected pair stops after the first failing axis with no result,
// and a start or unused command leaves the block idle. in_stall is high in every state
// but idle. The result register is separate, so a new request may be accepted while a
// result still waits on out_stall. Configuration writes are always accepted and must
// only be made while the block is idle.
module cell_list_pair_filter_unit import clpf_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// Configuration write channel.
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [INV_W-1:0]         cfg_data,
	// Request channel.
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [CMD_W-1:0]         command,
	input  logic [CONTACT_W-1:0]     contact_index,
	input  logic [BEAD_W-1:0]        first_bead,
	input  logic [BEAD_W-1:0]        second_bead,
	input  logic [KIND_W-1:0]        first_kind,
	input  logic [KIND_W-1:0]        second_kind,
	input  logic signed [POS_W-1:0]  first_pos_x,
	input  logic signed [POS_W-1:0]  first_pos_y,
	input  logic signed [POS_W-1:0]  first_pos_z,
	input  logic signed [POS_W-1:0]  second_pos_x,
	input  logic signed [POS_W-1:0]  second_pos_y,
	input  logic signed [POS_W-1:0]  second_pos_z,
	// Result channel.
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     list_kind,
	output logic [CNT_W-1:0]         list_slot,
	output logic [CONTACT_W-1:0]     source_contact,
	output logic [BEAD_W-1:0]        kept_first_bead,
	output logic [BEAD_W-1:0]        kept_second_bead,
	output logic [KIND_W-1:0]        kept_first_kind,
	output logic [KIND_W-1:0]        kept_second_kind
);

	state_t state_q, state_d;

	// Configuration registers.
	logic [INV_W-1:0] inv_q;
	logic [CPS_W-1:0] cps_q;

	// Captured request.
	logic                    repulse_q;
	logic [CONTACT_W-1:0]    contact_q;
	logic [BEAD_W-1:0]       first_bead_q, second_bead_q;
	logic [KIND_W-1:0]       first_kind_q, second_kind_q;
	logic signed [POS_W-1:0] first_pos_q  [AXES];
	logic signed [POS_W-1:0] second_pos_q [AXES];
	logic [AXIS_W-1:0]       axis_q;

	// List counters.
	logic [CNT_W-1:0] attract_cnt_q, repulse_cnt_q;

	// Result register.
	logic                 out_valid_q;
	logic                 list_kind_q;
	logic [CNT_W-1:0]     list_slot_q;
	logic [CONTACT_W-1:0] source_contact_q;
	logic [BEAD_W-1:0]    kept_first_bead_q, kept_second_bead_q;
	logic [KIND_W-1:0]    kept_first_kind_q, kept_second_kind_q;

	// Datapath.
	logic signed [POS_W-1:0]  mul_pos;
	logic signed [CELL_W-1:0] cell_s1;
	logic signed [CELL_W-1:0] cell_first_q;
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]        diff_mag;
	logic                     rem_near;
	mod_res_t                 mod_res;

	// Sequencer controls.
	logic clear_counts;
	logic load_item;
	logic sel_second;
	logic capture_first;
	logic mod_start;
	logic axis_pass;
	logic axis_next;
	logic emit;

	logic [CNT_W-1:0] cur_count;
	logic             count_room;
	logic [CNT_W-1:0] slot_next;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_q <= INV_RESET;
			cps_q <= CPS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_INV_CELL_SIZE: inv_q <= cfg_data;
				CFG_CELLS_PER_SIDE: cps_q <= cfg_data[CPS_W-1:0];
				default: ;
			endcase
		end
	end

	// The shared multiplier sees the first bead's coordinate, then the second's.
	assign mul_pos = sel_second ? second_pos_q[axis_q] : first_pos_q[axis_q];

	clpf_cell_index u_cell_index (
		.clk     (clk),
		.pos     (mul_pos),
		.inv     (inv_q),
		.cell_s1 (cell_s1)
	);

	// In the difference cycle cell_s1 holds the second bead's index.
	assign diff     = {cell_first_q[CELL_W-1], cell_first_q} - {cell_s1[CELL_W-1], cell_s1};
	assign diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

	clpf_mod_unit u_mod_unit (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (diff_mag),
		.divisor  (cps_q),
		.res      (mod_res)
	);

	// The wrapped difference of -d is the negative of that of d, so testing the remainder
	// of the magnitude for 0, 1 or n - 1 covers both signs.
	assign rem_near = (mod_res.rem == '0) || (mod_res.rem == CPS_W'(1)) ||
			(mod_res.rem == cps_q - 1'b1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_stall      = 1'b1;
		clear_counts  = 1'b0;
		load_item     = 1'b0;
		sel_second    = 1'b0;
		capture_first = 1'b0;
		mod_start     = 1'b0;
		axis_pass     = 1'b0;
		axis_next     = 1'b0;
		emit          = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (command)
						CMD_START: clear_counts = 1'b1;
						CMD_ATTRACT, CMD_REPULSE: begin
							load_item = 1'b1;
							state_d   = ST_MUL_FIRST;
						end
						default: ;
					endcase
				end
			end
			ST_MUL_FIRST: begin
				state_d = ST_MUL_SECOND;
			end
			ST_MUL_SECOND: begin
				sel_second    = 1'b1;
				capture_first = 1'b1;
				state_d       = ST_DIFF;
			end
			ST_DIFF: begin
				if (cps_q == '0) begin
					// Without a periodic box the raw difference must lie in -1..+1.
					if (diff_mag <= DIFF_W'(1)) begin
						axis_pass = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end else begin
					mod_start = 1'b1;
					state_d   = ST_MOD;
				end
			end
			ST_MOD: begin
				if (mod_res.done) begin
					if (rem_near) begin
						axis_pass = 1'b1;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || !out_stall) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (axis_pass) begin
			if (axis_q == AXIS_LAST) begin
				state_d = ST_EMIT;
			end else begin
				axis_next = 1'b1;
				state_d   = ST_MUL_FIRST;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= '0;
		end else if (load_item) begin
			axis_q <= '0;
		end else if (axis_next) begin
			axis_q <= axis_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_item) begin
			repulse_q       <= (command == CMD_REPULSE);
			contact_q       <= contact_index;
			first_bead_q    <= first_bead;
			second_bead_q   <= second_bead;
			first_kind_q    <= first_kind;
			second_kind_q   <= second_kind;
			first_pos_q[0]  <= first_pos_x;
			first_pos_q[1]  <= first_pos_y;
			first_pos_q[2]  <= first_pos_z;
			second_pos_q[0] <= second_pos_x;
			second_pos_q[1] <= second_pos_y;
			second_pos_q[2] <= second_pos_z;
		end
		if (capture_first) begin
			cell_first_q <= cell_s1;
		end
	end

	// A full list keeps its count and hands out slot 0.
	assign cur_count  = repulse_q ? repulse_cnt_q : attract_cnt_q;
	assign count_room = (cur_count < COUNT_LIMIT);
	assign slot_next  = count_room ? cur_count + 1'b1 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attract_cnt_q <= '0;
			repulse_cnt_q <= '0;
		end else if (clear_counts) begin
			attract_cnt_q <= '0;
			repulse_cnt_q <= '0;
		end else if (emit && count_room) begin
			if (repulse_q) begin
				repulse_cnt_q <= slot_next;
			end else begin
				attract_cnt_q <= slot_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			list_kind_q        <= repulse_q;
			list_slot_q        <= slot_next;
			source_contact_q   <= contact_q;
			kept_first_bead_q  <= first_bead_q;
			kept_second_bead_q <= second_bead_q;
			kept_first_kind_q  <= first_kind_q;
			kept_second_kind_q <= second_kind_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign list_kind        = list_kind_q;
	assign list_slot        = list_slot_q;
	assign source_contact   = source_contact_q;
	assign kept_first_bead  = kept_first_bead_q;
	assign kept_second_bead = kept_second_bead_q;
	assign kept_first_kind  = kept_first_kind_q;
	assign kept_second_kind = kept_second_kind_q;

endmodule

// File: rtl/clpf_checker.sv
`include "assert_macros.svh"

// Port-level checks of the pair filter.
module clpf_checker import clpf_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [CMD_W-1:0]     command,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic                 list_kind,
	input logic [CNT_W-1:0]     list_slot,
	input logic [CONTACT_W-1:0] source_contact,
	input logic [BEAD_W-1:0]    kept_first_bead,
	input logic [BEAD_W-1:0]    kept_second_bead,
	input logic [KIND_W-1:0]    kept_first_kind,
	input logic [KIND_W-1:0]    kept_second_kind
);

	logic                                          out_waiting;
	logic                                          pair_taken;
	logic                                          start_taken;
	logic [CNT_W+CONTACT_W+2*BEAD_W+2*KIND_W:0]    out_payload;

	assign out_waiting = out_valid && out_stall;
	assign pair_taken  = in_valid && !in_stall &&
			(command == CMD_ATTRACT || command == CMD_REPULSE);
	assign start_taken = in_valid && !in_stall && (command == CMD_START);
	assign out_payload = {list_kind, list_slot, source_contact, kept_first_bead,
			kept_second_bead, kept_first_kind, kept_second_kind};

	`CLPF_ASSERT_NEXT(a_out_valid_held, clk, arst_n, out_waiting, out_valid)

	`CLPF_ASSERT_NEXT(a_out_payload_held, clk, arst_n, out_waiting, $stable(out_payload))

	`CLPF_ASSERT_NEXT(a_pair_busy, clk, arst_n, pair_taken, in_stall)

	`CLPF_ASSERT_NEXT(a_start_single_cycle, clk, arst_n, start_taken, !in_stall)

	`CLPF_ASSERT_NOW(a_result_after_work, clk, arst_n, $rose(out_valid), $past(in_stall))

endmodule

bind cell_list_pair_filter_unit clpf_checker u_clpf_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in_valid),
	.in_stall         (in_stall),
	.command          (command),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.list_kind        (list_kind),
	.list_slot        (list_slot),
	.source_contact   (source_contact),
	.kept_first_bead  (kept_first_bead),
	.kept_second_bead (kept_second_bead),
	.kept_first_kind  (kept_first_kind),
	.kept_second_kind (kept_second_kind)
);

// File: dv/tb.sv
// Testbench for the periodic cell-list pair filter.
//
// A request carries one candidate bead pair, tagged for the attractive or the
// repulsive list, with both beads' unwrapped positions. The testbench keeps its
// own model of the cell grid (inverse cell size and cells per side) and of the
// two list counts. For every accepted request it works out whether the pair is
// kept and, if so, which slot it takes. The expected kept pairs wait in a queue
// and are compared field by field with what the block returns, in order.
//
// The run is split into named tests: directed pairs on the reset grid, pairs on
// the extreme grids (including a grid with no periodic wrap), random traffic over
// a series of grid settings, and a closing burst with no idling on either side.
module tb;
	import clpf_pkg::*;

	// The command code that the block must ignore.
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// List tags as they appear on the result.
	localparam logic LIST_ATTRACT = 1'b0;
	localparam logic LIST_REPULSE = 1'b1;

	// A list holds at most this many entries; the count saturates there.
	localparam logic [CNT_W-1:0] LIST_CAP = 16'hFFFF;

	// One whole cell at the reset grid, and the extremes of a position.
	localparam logic signed [POS_W-1:0] CELL_ONE = 32'sh0001_0000;
	localparam logic signed [POS_W-1:0] POS_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [POS_W-1:0] POS_MIN  = 32'sh8000_0000;

	// Allowance for a kept pair to pass through the block; a little margin is added on top.
	localparam int SETTLE_CYCLES   = 48;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int REPORT_LIMIT    = 10;
	localparam int RANDOM_PHASES   = 10;
	localparam int PHASE_REQUESTS  = 75;
	localparam int CLOSING_REQUESTS = 100;

	typedef struct {
		logic [CMD_W-1:0]        command;
		logic [CONTACT_W-1:0]    contact;
		logic [BEAD_W-1:0]       bead_a;
		logic [BEAD_W-1:0]       bead_b;
		logic [KIND_W-1:0]       kind_a;
		logic [KIND_W-1:0]       kind_b;
		logic signed [POS_W-1:0] ax;
		logic signed [POS_W-1:0] ay;
		logic signed [POS_W-1:0] az;
		logic signed [POS_W-1:0] bx;
		logic signed [POS_W-1:0] by;
		logic signed [POS_W-1:0] bz;
	} pair_request_t;

	typedef struct packed {
		logic                 which_list;
		logic [CNT_W-1:0]     slot;
		logic [CONTACT_W-1:0] contact;
		logic [BEAD_W-1:0]    bead_a;
		logic [BEAD_W-1:0]    bead_b;
		logic [KIND_W-1:0]    kind_a;
		logic [KIND_W-1:0]    kind_b;
	} kept_pair_t;

	// Every input of the block starts at a known value.
	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_W-1:0]     cfg_index = '0;
	logic [INV_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [CMD_W-1:0]         command = '0;
	logic [CONTACT_W-1:0]     contact_index = '0;
	logic [BEAD_W-1:0]        first_bead = '0;
	logic [BEAD_W-1:0]        second_bead = '0;
	logic [KIND_W-1:0]        first_kind = '0;
	logic [KIND_W-1:0]        second_kind = '0;
	logic signed [POS_W-1:0]  first_pos_x = '0;
	logic signed [POS_W-1:0]  first_pos_y = '0;
	logic signed [POS_W-1:0]  first_pos_z = '0;
	logic signed [POS_W-1:0]  second_pos_x = '0;
	logic signed [POS_W-1:0]  second_pos_y = '0;
	logic signed [POS_W-1:0]  second_pos_z = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     list_kind;
	logic [CNT_W-1:0]         list_slot;
	logic [CONTACT_W-1:0]     source_contact;
	logic [BEAD_W-1:0]        kept_first_bead;
	logic [BEAD_W-1:0]        kept_second_bead;
	logic [KIND_W-1:0]        kept_first_kind;
	logic [KIND_W-1:0]        kept_second_kind;

	// The model's copy of the grid registers and of the two list counts.
	logic [INV_W-1:0] grid_inv = 32'h0001_0000;
	logic [CPS_W-1:0] grid_cps = 12'd16;
	logic [CNT_W-1:0] attract_fill = '0;
	logic [CNT_W-1:0] repulse_fill = '0;

	kept_pair_t expected_kept_pairs[$];

	// Idling controls: the tests switch these on and off per phase.
	bit sender_gaps = 1'b1;
	bit receiver_stalls = 1'b1;

	int mismatches = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int full_slots_seen = 0;
	int config_writes = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	cell_list_pair_filter_unit dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// The cell index of one coordinate is the floor of the exact Q32.32 product of
	// the signed Q16.16 position and the unsigned Q16.16 inverse cell size. The
	// product always fits in 64 signed bits, and an arithmetic shift is the floor.
	function automatic longint cell_of(input logic signed [POS_W-1:0] pos);
		longint product;
		product = longint'(pos) * longint'(grid_inv);
		return product >>> 32;
	endfunction

	// On one axis the pair is near when the index difference, wrapped to the
	// periodic box, is zero or one cell either way. With zero cells per side
	// there is no wrap and the raw difference decides.
	function automatic bit axis_near(input logic signed [POS_W-1:0] a,
			input logic signed [POS_W-1:0] b);
		longint d;
		longint n;
		longint r;
		d = cell_of(a) - cell_of(b);
		n = longint'(grid_cps);
		if (n == 0)
			return (d >= -1) && (d <= 1);
		r = d % n;
		if (r < 0)
			r += n;
		return (r == 0) || (r == 1) || (r == n - 1);
	endfunction

	// Advances the model by one request. Returns 1 with the expected result when
	// the request yields a kept pair.
	function automatic bit predict_kept_pair(input pair_request_t req, output kept_pair_t res);
		logic [CNT_W-1:0] slot;
		res = '0;
		if (req.command == CMD_START) begin
			attract_fill = '0;
			repulse_fill = '0;
			return 1'b0;
		end
		if (req.command == CMD_UNUSED)
			return 1'b0;
		if (!(axis_near(req.ax, req.bx) && axis_near(req.ay, req.by) &&
				axis_near(req.az, req.bz)))
			return 1'b0;
		// A full list still reports the pair, but with slot zero.
		if (req.command == CMD_ATTRACT) begin
			if (attract_fill < LIST_CAP) begin
				attract_fill++;
				slot = attract_fill;
			end else begin
				slot = '0;
			end
			res.which_list = LIST_ATTRACT;
		end else begin
			if (repulse_fill < LIST_CAP) begin
				repulse_fill++;
				slot = repulse_fill;
			end else begin
				slot = '0;
			end
			res.which_list = LIST_REPULSE;
		end
		res.slot    = slot;
		res.contact = req.contact;
		res.bead_a  = req.bead_a;
		res.bead_b  = req.bead_b;
		res.kind_a  = req.kind_a;
		res.kind_b  = req.kind_b;
		return 1'b1;
	endfunction

	// A request at the given positions, with random identifiers and type codes.
	function automatic pair_request_t pair_at(input logic [CMD_W-1:0] cmd,
			input logic signed [POS_W-1:0] ax, input logic signed [POS_W-1:0] ay,
			input logic signed [POS_W-1:0] az, input logic signed [POS_W-1:0] bx,
			input logic signed [POS_W-1:0] by, input logic signed [POS_W-1:0] bz);
		pair_request_t req;
		req.command = cmd;
		req.contact = CONTACT_W'($urandom);
		req.bead_a  = BEAD_W'($urandom);
		req.bead_b  = BEAD_W'($urandom);
		req.kind_a  = KIND_W'($urandom);
		req.kind_b  = KIND_W'($urandom);
		req.ax = ax;
		req.ay = ay;
		req.az = az;
		req.bx = bx;
		req.by = by;
		req.bz = bz;
		return req;
	endfunction

	// A position within about a cell and a half of the given one. Now and then
	// it is moved by a whole box as well, so that the two beads are neighbours
	// only through the periodic boundary.
	function automatic logic signed [POS_W-1:0] neighbour_of(
			input logic signed [POS_W-1:0] pos, input longint cell_len, input longint span);
		longint moved;
		moved = longint'(pos) + longint'($urandom_range(0, 32'(2 * span))) - span;
		if (grid_cps != 0 && $urandom_range(0, 3) == 0)
			moved += ($urandom_range(0, 1) ? 1 : -1) * longint'(grid_cps) * cell_len;
		return POS_W'(moved);
	endfunction

	// Random request. Well-formed pairs have the second bead placed near the first
	// on the current grid, so most of them are kept; the rest are fully random.
	function automatic pair_request_t random_pair(input bit well_formed);
		pair_request_t req;
		longint cell_len;
		longint span;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 4)
			req = pair_at(CMD_START, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		else if (pick < 7)
			req = pair_at(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		else if (pick < 55)
			req = pair_at(CMD_ATTRACT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		else
			req = pair_at(CMD_REPULSE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		if (well_formed) begin
			cell_len = (grid_inv == 0) ? (longint'(1) << 32) :
				(longint'(1) << 32) / longint'(grid_inv);
			span = cell_len + cell_len / 2;
			if (span > (longint'(1) << 30))
				span = longint'(1) << 30;
			req.bx = neighbour_of(req.ax, cell_len, span);
			req.by = neighbour_of(req.ay, cell_len, span);
			req.bz = neighbour_of(req.az, cell_len, span);
		end
		return req;
	endfunction

	// Presents one request and holds it until the block takes it. Valid is left
	// high on return, so that a following request goes out back to back; it is
	// only lowered when the sender really pauses.
	task automatic send_pair(input pair_request_t req);
		kept_pair_t res;
		if (sender_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		command       <= req.command;
		contact_index <= req.contact;
		first_bead    <= req.bead_a;
		second_bead   <= req.bead_b;
		first_kind    <= req.kind_a;
		second_kind   <= req.kind_b;
		first_pos_x   <= req.ax;
		first_pos_y   <= req.ay;
		first_pos_z   <= req.az;
		second_pos_x  <= req.bx;
		second_pos_y  <= req.by;
		second_pos_z  <= req.bz;
		do @(posedge clk); while (in_stall);
		requests_sent++;
		if (predict_kept_pair(req, res))
			expected_kept_pairs.push_back(res);
	endtask

	// Stops sending and waits until every expected pair has come back. A rejected
	// pair gives nothing back, so a further block latency is allowed to pass before
	// the block can be taken as idle.
	task automatic wait_for_idle();
		in_valid <= 1'b0;
		while (expected_kept_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes both grid registers, back to back. The cells-per-side write carries
	// random upper bits that the register must drop.
	task automatic set_grid(input logic [INV_W-1:0] inv, input logic [CPS_W-1:0] cps);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_INV_CELL_SIZE;
		cfg_data  <= inv;
		do @(posedge clk); while (!cfg_ready);
		grid_inv = inv;
		cfg_index <= CFG_CELLS_PER_SIDE;
		cfg_data  <= {(INV_W - CPS_W)'($urandom), cps};
		do @(posedge clk); while (!cfg_ready);
		grid_cps = cps;
		cfg_valid <= 1'b0;
		config_writes += 2;
	endtask

	// Directed pairs on the reset grid: one cell per unit and sixteen cells a side.
	task automatic test_reset_grid();
		pair_request_t req;
		// Same cell, with every identifier and type code at its lowest.
		req = pair_at(CMD_ATTRACT, 0, 0, 0, 0, 0, 0);
		req.contact = '0;
		req.bead_a  = '0;
		req.bead_b  = '0;
		req.kind_a  = '0;
		req.kind_b  = '0;
		send_pair(req);
		// Neighbouring cells on the repulsive list, identifiers at their highest.
		req = pair_at(CMD_REPULSE, CELL_ONE + CELL_ONE / 2, 2 * CELL_ONE, 3 * CELL_ONE,
			5 * CELL_ONE / 2, CELL_ONE, 3 * CELL_ONE);
		req.contact = '1;
		req.bead_a  = '1;
		req.bead_b  = '1;
		req.kind_a  = '1;
		req.kind_b  = '1;
		send_pair(req);
		// Two cells apart: dropped.
		send_pair(pair_at(CMD_ATTRACT, 0, 0, 0, 2 * CELL_ONE, 0, 0));
		// Fifteen cells apart is one cell across the box edge: kept.
		send_pair(pair_at(CMD_ATTRACT, 0, 0, 0, 15 * CELL_ONE, 0, 0));
		// A whole box apart is the same cell: kept.
		send_pair(pair_at(CMD_ATTRACT, 0, 0, 0, 0, 16 * CELL_ONE, 0));
		// Positions at both extremes of the field.
		send_pair(pair_at(CMD_ATTRACT, POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN));
		// The smallest negative position floors to cell -1, two cells from cell 1.
		send_pair(pair_at(CMD_ATTRACT, 0, 0, -1, 0, 0, CELL_ONE));
		send_pair(pair_at(CMD_REPULSE, -1, 0, 0, 0, 0, 0));
		// An unused command changes nothing; a start clears both counts.
		send_pair(pair_at(CMD_UNUSED, 0, 0, 0, 0, 0, 0));
		send_pair(pair_at(CMD_START, 0, 0, 0, 0, 0, 0));
		send_pair(pair_at(CMD_ATTRACT, 0, 0, 0, 0, 0, 0));
		send_pair(pair_at(CMD_REPULSE, 0, 0, 0, 0, 0, 0));
	endtask

	// Directed pairs on the extreme grids.
	task automatic test_grid_extremes();
		// The largest inverse size: each raw position step is almost a cell.
		wait_for_idle();
		set_grid(32'hFFFF_FFFF, 12'd4095);
		send_pair(pair_at(CMD_ATTRACT, 0, 0, 0, 2, 0, 0));
		send_pair(pair_at(CMD_ATTRACT, 0, 0, 0, 3, 0, 0));
		send_pair(pair_at(CMD_REPULSE, 0, 0, 0, 0, -1, 0));
		send_pair(pair_at(CMD_ATTRACT, POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN));
		// The smallest nonzero grid: every pair lies in the single cell.
		wait_for_idle();
		set_grid(32'd1, 12'd1);
		send_pair(pair_at(CMD_ATTRACT, POS_MAX, POS_MIN, POS_MAX, POS_MIN, POS_MAX, POS_MIN));
		// Zero cells per side: no periodic wrap at all.
		wait_for_idle();
		set_grid(CELL_ONE, '0);
		send_pair(pair_at(CMD_ATTRACT, 0, 0, 0, CELL_ONE, -CELL_ONE, 0));
		send_pair(pair_at(CMD_ATTRACT, 0, 0, 0, 2 * CELL_ONE, 0, 0));
		send_pair(pair_at(CMD_REPULSE, 0, 0, 0, 0, 0, 16 * CELL_ONE));
		// A zero inverse size puts every bead into cell zero.
		wait_for_idle();
		set_grid('0, 12'd2);
		send_pair(pair_at(CMD_REPULSE, POS_MIN, POS_MAX, 0, POS_MAX, POS_MIN, -1));
	endtask

	// Random traffic over a series of grid settings. Each phase starts from an idle
	// block, so the sender waits here until every expected pair has come back.
	task automatic test_random_traffic();
		logic [INV_W-1:0] inv;
		logic [CPS_W-1:0] cps;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_for_idle();
			case ($urandom_range(0, 6))
				0: inv = '0;
				1: inv = 32'd1;
				2: inv = 32'hFFFF_FFFF;
				3: inv = $urandom;
				4: inv = $urandom_range(32'h0000_4000, 32'h0004_0000);
				5: inv = $urandom_range(1, 255);
				default: inv = 32'h0001_0000;
			endcase
			case ($urandom_range(0, 6))
				0: cps = '0;
				1: cps = 12'd1;
				2: cps = 12'd2;
				3: cps = 12'd4095;
				4: cps = CPS_W'($urandom_range(1, 4095));
				default: cps = CPS_W'($urandom_range(3, 20));
			endcase
			set_grid(inv, cps);
			// Some phases run with no idling on one side or both.
			sender_gaps = $urandom_range(0, 3) != 0;
			receiver_stalls = $urandom_range(0, 3) != 0;
			for (int i = 0; i < PHASE_REQUESTS; i++)
				send_pair(random_pair($urandom_range(0, 9) != 0));
		end
	endtask

	// Closing burst at full rate on the reset grid.
	task automatic test_closing_burst();
		wait_for_idle();
		set_grid(CELL_ONE, 12'd16);
		sender_gaps = 1'b0;
		receiver_stalls = 1'b0;
		for (int i = 0; i < CLOSING_REQUESTS; i++)
			send_pair(random_pair($urandom_range(0, 9) != 0));
	endtask

	// Receiver stalls come in random bursts; a new burst only begins once out_stall has
	// fallen after the last one.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (receiver_stalls && !out_stall && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(1, 15) - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Every returned pair is checked against the oldest expectation.
	always @(posedge clk) begin
		kept_pair_t got;
		kept_pair_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{list_kind, list_slot, source_contact, kept_first_bead, kept_second_bead,
				kept_first_kind, kept_second_kind};
			results_checked++;
			if (got.slot == '0)
				full_slots_seen++;
			if (expected_kept_pairs.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$display("Unexpected pair: list %0d slot %0d contact %0d",
						got.which_list, got.slot, got.contact);
				mismatches++;
			end else begin
				want = expected_kept_pairs.pop_front();
				if (got.which_list !== want.which_list || got.slot !== want.slot ||
						got.contact !== want.contact || got.bead_a !== want.bead_a ||
						got.bead_b !== want.bead_b || got.kind_a !== want.kind_a ||
						got.kind_b !== want.kind_b) begin
					if (mismatches < REPORT_LIMIT) begin
						$display("Pair mismatch: expected list %0d slot %0d contact %0d %s",
							want.which_list, want.slot, want.contact, "");
						$display("  expected beads %0d/%0d kinds %0d/%0d",
							want.bead_a, want.bead_b, want.kind_a, want.kind_b);
						$display("  got list %0d slot %0d contact %0d",
							got.which_list, got.slot, got.contact);
						$display("  got beads %0d/%0d kinds %0d/%0d",
							got.bead_a, got.bead_b, got.kind_a, got.kind_b);
					end
					mismatches++;
				end
			end
		end
	end

	// The watchdog ends the run when nothing at all has been accepted for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_grid();
		test_grid_extremes();
		test_random_traffic();
		test_closing_burst();
		wait_for_idle();
		$display("Sent %0d requests, checked %0d kept pairs (%0d of them on a full list).",
			requests_sent, results_checked, full_slots_seen);
		$display("Made %0d register writes across the grid settings; %0d mismatches.",
			config_writes, mismatches);
		if (mismatches == 0 && expected_kept_pairs.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/clpf_pkg.sv
rtl/clpf_cell_index.sv
rtl/clpf_mod_unit.sv
rtl/cell_list_pair_filter_unit.sv
rtl/clpf_checker.sv
dv/tb.sv
